// ===== rtl/core/scint_pkg.sv =====
`default_nettype none
package scint_pkg;

  localparam int CW     = 32;   // width of every coordinate and curvature field
  localparam int DW     = 33;   // exact width of a difference of two fields
  localparam int PW     = 66;   // width of a signed product of two differences
  localparam int ABW    = 66;   // squared lengths
  localparam int DOTW   = 67;   // signed dot product
  localparam int DKW    = 32;   // magnitude of the curvature difference
  localparam int REM_W  = 128;  // partial remainder of the root and divide chain
  localparam int ROOT_W = 64;   // root or quotient built one bit per stage
  localparam int SUB_W  = 194;  // candidate subtrahend, wide enough for any shift
  localparam int NSTEPS = ROOT_W;
  localparam int DLW    = 35;   // correction after limiting
  localparam int IN_W   = 8 * CW;

  localparam logic [DLW-1:0] DELTA_MAX = 35'h4_0000_0000;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [REM_W-1:0]    tacc;
    logic [ROOT_W-1:0]   root;
    logic [ABW-1:0]      ab2;
    logic [DKW-1:0]      dk_mag;
    logic signed [CW-1:0] ka;
    logic                behind;
    logic                degen;
    logic                ovf;
    logic                dk_neg;
  } step_t;

  typedef struct packed {
    logic signed [CW-1:0] kappa;
    logic                 saturated;
    logic                 degenerate;
    logic                 query_behind;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/scint_front.sv =====
`default_nettype none
module scint_front
  import scint_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire logic [IN_W-1:0] in_data,
  output step_t                s_o,
  output logic                 v_o
);

  logic signed [CW-1:0] a_x, a_y, ka, b_x, b_y, kb, q_x, q_y;
  assign a_x = signed'(in_data[31:0]);
  assign a_y = signed'(in_data[63:32]);
  assign ka  = signed'(in_data[95:64]);
  assign b_x = signed'(in_data[127:96]);
  assign b_y = signed'(in_data[159:128]);
  assign kb  = signed'(in_data[191:160]);
  assign q_x = signed'(in_data[223:192]);
  assign q_y = signed'(in_data[255:224]);

  logic [4:0] v_r;

  // Stage 1: differences.
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, dk_r;
  logic signed [CW-1:0] ka1_r;
  logic                 dg1_r;

  // Stage 2: products.
  logic signed [PW-1:0] puv_x_r, puv_y_r, uu_x_r, uu_y_r, vv_x_r, vv_y_r;
  logic [DKW-1:0]       dkm2_r;
  logic                 dkn2_r, dg2_r;
  logic signed [CW-1:0] ka2_r;
  logic [DKW-1:0]       dkm2_nxt;

  // Stage 3: sums.
  logic signed [DOTW-1:0] dot_r, dot_nxt;
  logic [ABW-1:0]         ab2_3_r, ac2_3_r, ab2_nxt, ac2_nxt;
  logic [DKW-1:0]         dkm3_r;
  logic                   dkn3_r, dg3_r;
  logic signed [CW-1:0]   ka3_r;

  // Stage 4: curvature difference times dot product, in two halves.
  logic [DKW+32:0]      mlo_r, mhi_r;
  logic [ABW-1:0]       ab2_4_r, ac2_4_r;
  logic [DKW-1:0]       dkm4_r;
  logic                 dkn4_r, dg4_r, bh4_r;
  logic signed [CW-1:0] ka4_r;

  // Stage 5: starting remainder for the root or the quotient.
  step_t           s_r, s_nxt;
  logic [REM_W-1:0] num, sq;

  assign dkm2_nxt = dk_r[DW-1] ? DKW'(-dk_r) : DKW'(dk_r);
  assign dot_nxt  = DOTW'(puv_x_r) + DOTW'(puv_y_r);
  assign ab2_nxt  = ABW'($unsigned(uu_x_r)) + ABW'($unsigned(uu_y_r));
  assign ac2_nxt  = ABW'($unsigned(vv_x_r)) + ABW'($unsigned(vv_y_r));

  always_comb begin
    num = (REM_W'(mhi_r) << 34) + (REM_W'(mlo_r) << 1) + REM_W'(ab2_4_r);
    sq  = REM_W'(ac2_4_r) << 62;
    s_nxt.rem    = bh4_r ? sq : num;
    s_nxt.tacc   = '0;
    s_nxt.root   = '0;
    s_nxt.ab2    = ab2_4_r;
    s_nxt.dk_mag = dkm4_r;
    s_nxt.ka     = ka4_r;
    s_nxt.behind = bh4_r;
    s_nxt.degen  = dg4_r;
    // The quotient would not fit the bit chain: the correction is limited anyway.
    s_nxt.ovf    = !bh4_r && (ABW'(num[REM_W-1:65]) >= ab2_4_r);
    s_nxt.dk_neg = dkn4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r    <= DW'(b_x) - DW'(a_x);
      uy_r    <= DW'(b_y) - DW'(a_y);
      vx_r    <= DW'(q_x) - DW'(a_x);
      vy_r    <= DW'(q_y) - DW'(a_y);
      dk_r    <= DW'(kb) - DW'(ka);
      ka1_r   <= ka;
      dg1_r   <= (a_x == b_x) && (a_y == b_y);

      puv_x_r <= PW'(ux_r) * PW'(vx_r);
      puv_y_r <= PW'(uy_r) * PW'(vy_r);
      uu_x_r  <= PW'(ux_r) * PW'(ux_r);
      uu_y_r  <= PW'(uy_r) * PW'(uy_r);
      vv_x_r  <= PW'(vx_r) * PW'(vx_r);
      vv_y_r  <= PW'(vy_r) * PW'(vy_r);
      dkm2_r  <= dkm2_nxt;
      dkn2_r  <= dk_r[DW-1];
      dg2_r   <= dg1_r;
      ka2_r   <= ka1_r;

      dot_r   <= dot_nxt;
      ab2_3_r <= ab2_nxt;
      ac2_3_r <= ac2_nxt;
      dkm3_r  <= dkm2_r;
      dkn3_r  <= dkn2_r;
      dg3_r   <= dg2_r;
      ka3_r   <= ka2_r;

      mlo_r   <= (DKW+33)'(dkm3_r) * (DKW+33)'(dot_r[32:0]);
      mhi_r   <= (DKW+33)'(dkm3_r) * (DKW+33)'(dot_r[65:33]);
      ab2_4_r <= ab2_3_r;
      ac2_4_r <= ac2_3_r;
      dkm4_r  <= dkm3_r;
      dkn4_r  <= dkn3_r;
      dg4_r   <= dg3_r;
      bh4_r   <= dot_r[DOTW-1];
      ka4_r   <= ka3_r;

      s_r     <= s_nxt;
    end
  end

  assign s_o = s_r;
  assign v_o = v_r[4];

endmodule
`default_nettype wire

// ===== rtl/core/scint_step.sv =====
`default_nettype none
module scint_step
  import scint_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire step_t s_i,
  input  wire logic  v_i,
  output step_t      s_o,
  output logic       v_o
);

  step_t            s_r, s_nxt;
  logic             v_r;
  logic [SUB_W-1:0] sub;
  logic             take;

  // Square root mode keeps tacc = root * ab2, so that setting this bit costs
  // 2 * tacc * 2^BIT + ab2 * 2^(2*BIT). Divide mode tries ab2 * 2^(BIT+1).
  always_comb begin
    if (s_i.behind) begin
      sub = (SUB_W'(s_i.tacc) << (BIT + 1)) + (SUB_W'(s_i.ab2) << (2 * BIT));
    end else begin
      sub = SUB_W'(s_i.ab2) << (BIT + 1);
    end
    take  = SUB_W'(s_i.rem) >= sub;
    s_nxt = s_i;
    if (take) begin
      s_nxt.rem  = s_i.rem - sub[REM_W-1:0];
      s_nxt.root = s_i.root | (ROOT_W'(1) << BIT);
      if (s_i.behind) begin
        s_nxt.tacc = s_i.tacc + (REM_W'(s_i.ab2) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_o = s_r;
  assign v_o = v_r;

endmodule
`default_nettype wire

// ===== rtl/core/scint_back.sv =====
`default_nettype none
module scint_back
  import scint_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire step_t s_i,
  input  wire logic  v_i,
  output res_t       r_o,
  output logic       v_o
);

  logic [2:0] v_r;

  // Stage 1: curvature difference times the ratio, in two halves.
  logic [DKW+31:0]      ph_r, pl_r;
  logic [ROOT_W-1:0]    root1_r;
  logic                 bh1_r, dg1_r, ovf1_r, neg1_r;
  logic signed [CW-1:0] ka1_r;

  // Stage 2: rounded and limited correction.
  logic [DKW+65:0]      full;
  logic [DKW+34:0]      dsel;
  logic [DLW-1:0]       delta_r, delta_nxt;
  logic                 bh2_r, dg2_r, neg2_r;
  logic signed [CW-1:0] ka2_r;

  // Stage 3: final sum and clipping.
  res_t                 r_r, r_nxt;
  logic signed [CW+4:0] sum;

  always_comb begin
    full = ((DKW+66)'(ph_r) << 32) + (DKW+66)'(pl_r) + ((DKW+66)'(1) << 30);
    if (bh1_r) begin
      dsel = (DKW+35)'(full >> 31);
    end else begin
      dsel = (DKW+35)'(root1_r);
    end
    if ((!bh1_r && ovf1_r) || (dsel > (DKW+35)'(DELTA_MAX))) begin
      delta_nxt = DELTA_MAX;
    end else begin
      delta_nxt = dsel[DLW-1:0];
    end
  end

  always_comb begin
    if (neg2_r) begin
      sum = (CW+5)'(ka2_r) - signed'((CW+5)'(delta_r));
    end else begin
      sum = (CW+5)'(ka2_r) + signed'((CW+5)'(delta_r));
    end
    r_nxt.query_behind = bh2_r;
    r_nxt.degenerate   = 1'b0;
    r_nxt.saturated    = 1'b0;
    r_nxt.kappa        = sum[CW-1:0];
    if (sum > (CW+5)'(32'sh7fff_ffff)) begin
      r_nxt.kappa     = 32'sh7fff_ffff;
      r_nxt.saturated = 1'b1;
    end else if (sum < (CW+5)'(32'sh8000_0000)) begin
      r_nxt.kappa     = 32'sh8000_0000;
      r_nxt.saturated = 1'b1;
    end
    if (dg2_r) begin
      r_nxt.kappa        = ka2_r;
      r_nxt.query_behind = 1'b0;
      r_nxt.saturated    = 1'b0;
      r_nxt.degenerate   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r    <= (DKW+32)'(s_i.dk_mag) * (DKW+32)'(s_i.root[63:32]);
      pl_r    <= (DKW+32)'(s_i.dk_mag) * (DKW+32)'(s_i.root[31:0]);
      root1_r <= s_i.root;
      bh1_r   <= s_i.behind;
      dg1_r   <= s_i.degen;
      ovf1_r  <= s_i.ovf;
      // Behind A the correction points against the curvature difference.
      neg1_r  <= s_i.behind ^ s_i.dk_neg;
      ka1_r   <= s_i.ka;

      delta_r <= delta_nxt;
      bh2_r   <= bh1_r;
      dg2_r   <= dg1_r;
      neg2_r  <= neg1_r;
      ka2_r   <= ka1_r;

      r_r     <= r_nxt;
    end
  end

  assign r_o = r_r;
  assign v_o = v_r[2];

endmodule
`default_nettype wire

// ===== rtl/core/scint_outbuf.sv =====
`default_nettype none
module scint_outbuf
  import scint_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire res_t d_i,
  input  wire logic v_i,
  output logic      pipe_en,
  output res_t      q_o,
  output logic      q_valid,
  input  wire logic q_ready
);

  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic take;

  assign pipe_en = !skid_v_r;
  assign take    = v_i && pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !q_ready) begin
      if (take) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !q_ready) begin
      if (take) begin
        skid_r <= d_i;
      end
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else if (take) begin
      out_r <= d_i;
    end
  end

  assign q_o     = out_r;
  assign q_valid = out_v_r;

endmodule
`default_nettype wire

// ===== rtl/core/segment_curvature_interpolator.sv =====
// Curvature at a query point C, interpolated linearly along track segment AB
// (coordinates signed Q16.16, curvatures signed Q8.24). C is placed on the
// segment by its projection, or at minus |AC| when it lies behind A, and the
// result is clipped to the 32-bit range with a flag. The block takes one
// request per clock while its output is not stalled. The front stages form
// the differences, products and dot product, a chain of 64 stages builds
// the quotient or the length ratio one bit per stage, the back stages scale,
// limit and add the correction, and the output register holds the result. A
// two-entry output buffer keeps the input ready while one result waits.
`default_nettype none
module segment_curvature_interpolator
  import scint_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // a_x, a_y, kappa_at_a, b_x, b_y, kappa_at_b, q_x, q_y (32 bits each)
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // kappa_out
  output logic [CW-1:0]        out_tdata,
  // query_behind, degenerate, saturated
  output logic [2:0]           out_tuser
);

  logic  en;
  step_t st   [NSTEPS+1];
  logic  stv  [NSTEPS+1];
  res_t  res, res_q;
  logic  res_v;

  scint_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_tvalid && in_tready),
    .in_data (in_tdata),
    .s_o     (st[0]),
    .v_o     (stv[0])
  );

  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    scint_step #(.BIT(NSTEPS - 1 - k)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_i   (st[k]),
      .v_i   (stv[k]),
      .s_o   (st[k+1]),
      .v_o   (stv[k+1])
    );
  end

  scint_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .s_i   (st[NSTEPS]),
    .v_i   (stv[NSTEPS]),
    .r_o   (res),
    .v_o   (res_v)
  );

  scint_outbuf u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_i     (res),
    .v_i     (res_v),
    .pipe_en (en),
    .q_o     (res_q),
    .q_valid (out_tvalid),
    .q_ready (out_tready)
  );

  assign in_tready = en;
  assign out_tdata = res_q.kappa;
  assign out_tuser = {res_q.saturated, res_q.degenerate, res_q.query_behind};

endmodule
`default_nettype wire

// ===== rtl/core/scint_chk.sv =====
`default_nettype none
module scint_chk
  import scint_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_tvalid,
  input wire logic            in_tready,
  input wire logic [IN_W-1:0] in_tdata,
  input wire logic            out_tvalid,
  input wire logic            out_tready,
  input wire logic [CW-1:0]   out_tdata,
  input wire logic [2:0]      out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result request changed while stalled");

  a_degen_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && !out_tuser[2])
    else $error("degenerate segment reported with other flags");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 32'h7fff_ffff || out_tdata == 32'h8000_0000)
    else $error("saturated result is not at a range limit");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind segment_curvature_interpolator scint_chk u_chk (.*);
`default_nettype wire
